// File: rtl/assert_macros.svh
// Assertion macros shared by the resize RTL.
// Both on clk; rst_n gates BIR_ASSERT only; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BIR_ASSERT(lbl, prop, msg)
`define BIR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/bir_pkg.sv
// Types, widths and codes for the bilinear resize block.
// No dependencies; imported by every module of the block.
`default_nettype none
package bir_pkg;

    localparam int MAX_DIM  = 256;
    localparam int IDX_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int SCALE_W  = 25;
    localparam int PIX_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int MEM_AW   = 2 * IDX_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_ROW_SCALE  = 2'd2,
        REG_COL_SCALE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  src_width;
        logic [SIZE_W-1:0]  src_height;
        logic [SCALE_W-1:0] row_scale;
        logic [SCALE_W-1:0] col_scale;
    } bir_cfg_t;

    // One classified word between front and back.
    typedef struct packed {
        logic              is_compute;
        logic [IDX_W-1:0]  row0;
        logic [IDX_W-1:0]  row1;
        logic [IDX_W-1:0]  col0;
        logic [IDX_W-1:0]  col1;
        logic [FRAC_W-1:0] frac_r;
        logic [FRAC_W-1:0] frac_c;
        logic [PIX_W-1:0]  pixel;
    } bir_job_t;

endpackage
`default_nettype wire

// File: rtl/bir_front.sv
// Front end: input stage, classification and per-axis coordinate mapping.
// Depends on bir_pkg.
`default_nettype none
module bir_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                command,
    input  wire logic [bir_pkg::IDX_W-1:0] pos_row,
    input  wire logic [bir_pkg::IDX_W-1:0] pos_col,
    input  wire logic [bir_pkg::PIX_W-1:0] pixel_in,
    input  wire bir_pkg::bir_cfg_t   cfg,
    output logic                     job_valid,
    input  wire logic                job_ready,
    output bir_pkg::bir_job_t        job
);
    import bir_pkg::*;

    localparam int PROD_W = SIZE_W + SCALE_W + 1;
    localparam int IP_W   = PROD_W - FRAC_W - 1;

    typedef struct packed {
        logic [IDX_W-1:0]  i0;
        logic [IDX_W-1:0]  i1;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    // Coordinate + 1 in Q.17 is (2k+1)*scale + 0.5; floor + 1 and fraction fall out.
    function automatic axis_t map_axis(logic [IDX_W-1:0] k, logic [SCALE_W-1:0] scale,
                                       logic [SIZE_W-1:0] size);
        logic [PROD_W-1:0] v;
        logic [IP_W-1:0]   ip;
        logic [IP_W-1:0]   ip_m1;
        logic [IDX_W-1:0]  last;
        axis_t             r;
        v     = PROD_W'({k, 1'b1}) * PROD_W'(scale) + (PROD_W'(1) << FRAC_W);
        ip    = v[PROD_W-1:FRAC_W+1];
        ip_m1 = (ip == '0) ? '0 : ip - IP_W'(1);
        if (size == '0)
            last = '0;
        else if (size >= SIZE_W'(MAX_DIM))
            last = IDX_W'(MAX_DIM - 1);
        else
            last = IDX_W'(size - SIZE_W'(1));
        r.i0   = (ip_m1 > IP_W'(last)) ? last : ip_m1[IDX_W-1:0];
        r.i1   = (ip > IP_W'(last)) ? last : ip[IDX_W-1:0];
        r.frac = v[FRAC_W:1];
        return r;
    endfunction

    logic              s_valid_reg;
    logic              s_cmd_reg;
    logic [IDX_W-1:0]  s_row_reg;
    logic [IDX_W-1:0]  s_col_reg;
    logic [PIX_W-1:0]  s_pix_reg;
    axis_t             row_map;
    axis_t             col_map;

    assign in_ready  = !s_valid_reg || job_ready;
    assign job_valid = s_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s_cmd_reg <= command;
            s_row_reg <= pos_row;
            s_col_reg <= pos_col;
            s_pix_reg <= pixel_in;
        end
    end

    always_comb
    begin
        row_map = map_axis(s_row_reg, cfg.row_scale, cfg.src_height);
        col_map = map_axis(s_col_reg, cfg.col_scale, cfg.src_width);
        job.is_compute = (s_cmd_reg == CMD_COMPUTE);
        job.pixel      = s_pix_reg;
        if (s_cmd_reg == CMD_COMPUTE)
        begin
            job.row0   = row_map.i0;
            job.row1   = row_map.i1;
            job.col0   = col_map.i0;
            job.col1   = col_map.i1;
            job.frac_r = row_map.frac;
            job.frac_c = col_map.frac;
        end
        else
        begin
            // load: row0/col0 carry the write position
            job.row0   = s_row_reg;
            job.row1   = s_row_reg;
            job.col0   = s_col_reg;
            job.col1   = s_col_reg;
            job.frac_r = '0;
            job.frac_c = '0;
        end
    end

endmodule
`default_nettype wire

// File: rtl/bir_queue.sv
// Two-entry queue of classified words between front and back.
// Depends on bir_pkg.
`default_nettype none
module bir_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire bir_pkg::bir_job_t push_job,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output bir_pkg::bir_job_t      pop_job
);
    import bir_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bir_job_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  rd_reg;
    logic [PTR_W-1:0]  rd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/bir_back.sv
// Back end: frame store, four-read blend sequencer, weight/product pipeline
// and a two-entry result buffer. Depends on bir_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bir_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire bir_pkg::bir_job_t job,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [bir_pkg::PIX_W-1:0] pixel_out
);
    import bir_pkg::*;

    localparam int WT_W  = FRAC_W + 1;
    localparam int W_W   = 2 * FRAC_W + 1;
    localparam int ACC_W = 2 * FRAC_W + PIX_W;
    localparam int RES_DEPTH = 2;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (2 * FRAC_W - 1);
    localparam logic [WT_W-1:0]  WT_ONE     = WT_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [1:0]        n_reg;
    logic [1:0]        n_next;
    bir_job_t          job_reg;
    logic [1:0]        pend_reg;
    logic [1:0]        pend_next;

    bir_job_t          cur_job;
    logic [1:0]        cur_n;
    logic              head_load;
    logic              head_cmp;
    logic              start_cmp;
    logic              issue_rd;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [WT_W-1:0]   wr;
    logic [WT_W-1:0]   wc;

    logic [PIX_W-1:0]  frame_mem [1 << MEM_AW];

    logic              a_valid_reg;
    logic              a_first_reg;
    logic              a_last_reg;
    logic [W_W-1:0]    w_reg;
    logic [PIX_W-1:0]  rd_reg;
    logic              b_valid_reg;
    logic              b_first_reg;
    logic              b_last_reg;
    logic [ACC_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic              res_push;
    logic              res_pop;

    logic [PIX_W-1:0]  res_mem [RES_DEPTH];
    logic              res_wr_reg;
    logic              res_rd_reg;
    logic [1:0]        res_cnt_reg;
    logic [1:0]        res_cnt_next;

    // Issue side: a load is one write; a compute starts with its first read
    // straight off the queue head, then three more from the held word.
    always_comb
    begin
        head_load = (state_reg == ST_IDLE) && job_valid && !job.is_compute;
        head_cmp  = (state_reg == ST_IDLE) && job_valid && job.is_compute;
        start_cmp = head_cmp && (pend_reg != 2'(RES_DEPTH));
        job_ready = head_load || start_cmp;
        mem_we    = head_load;
        issue_rd  = start_cmp || (state_reg == ST_READ);
        cur_job   = (state_reg == ST_IDLE) ? job : job_reg;
        cur_n     = (state_reg == ST_IDLE) ? 2'd0 : n_reg;
        wr        = cur_n[0] ? WT_W'(cur_job.frac_r) : WT_ONE - WT_W'(cur_job.frac_r);
        wc        = cur_n[1] ? WT_W'(cur_job.frac_c) : WT_ONE - WT_W'(cur_job.frac_c);
        if (mem_we)
            mem_addr = {job.row0, job.col0};
        else
            mem_addr = {cur_n[0] ? cur_job.row1 : cur_job.row0,
                        cur_n[1] ? cur_job.col1 : cur_job.col0};
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_cmp)
                begin
                    state_next = ST_READ;
                    n_next     = 2'd1;
                end
            end
            ST_READ:
            begin
                n_next = n_reg + 2'd1;
                if (n_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (start_cmp && !res_pop)
            pend_next = pend_reg + 2'd1;
        else if (res_pop && !start_cmp)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_cmp)
        begin
            job_reg <= job;
        end
    end

    // Single-port frame store, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= job.pixel;
        end
        if (issue_rd)
        begin
            rd_reg <= frame_mem[mem_addr];
        end
    end

    // Stage A: weight product alongside the read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue_rd;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_rd)
        begin
            a_first_reg <= (cur_n == 2'd0);
            a_last_reg  <= (cur_n == 2'd3);
            w_reg       <= W_W'((W_W + 1)'(wr) * (W_W + 1)'(wc));
        end
        if (a_valid_reg)
        begin
            b_first_reg <= a_first_reg;
            b_last_reg  <= a_last_reg;
            prod_reg    <= ACC_W'((ACC_W + 1)'(w_reg) * (ACC_W + 1)'(rd_reg));
        end
    end

    // Stage C: accumulate; seed with one half so the top bits round to nearest.
    assign acc_next = (b_first_reg ? ROUND_HALF : acc_reg) + prod_reg;
    assign res_push = b_valid_reg && b_last_reg;

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (res_push)
        begin
            res_mem[res_wr_reg] <= acc_next[ACC_W-1:2*FRAC_W];
        end
    end

    // Result buffer.
    assign out_valid = (res_cnt_reg != 2'd0);
    assign pixel_out = res_mem[res_rd_reg];
    assign res_pop   = out_valid && out_ready;

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
            res_cnt_next = res_cnt_reg + 2'd1;
        else if (res_pop && !res_push)
            res_cnt_next = res_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (res_push)
                res_wr_reg <= !res_wr_reg;
            if (res_pop)
                res_rd_reg <= !res_rd_reg;
            res_cnt_reg <= res_cnt_next;
        end
    end

    `BIR_ASSERT(a_buf_within_credit, res_cnt_reg <= pend_reg, "result buffer exceeds credit")
    `BIR_ASSERT(a_push_not_full, res_push |-> res_cnt_reg != 2'(RES_DEPTH), "result overflow")
    `BIR_ASSERT(a_last_tag_flows, a_valid_reg && a_last_reg |=> b_valid_reg && b_last_reg, "tag lost")
    `BIR_ASSERT(a_single_port, !(mem_we && issue_rd), "frame store port conflict")

endmodule
`default_nettype wire

// File: rtl/bilinear_image_resize.sv
// Top level of the bilinear resize block: APB register file and the
// front / queue / back chain. Depends on bir_pkg, bir_front, bir_queue, bir_back.
//
// Half-pixel-centred bilinear resize of one 16-bit channel. A load word
// (command 0) writes pixel_in into the 256 x 256 frame store at (pos_row,
// pos_col) and yields nothing; a compute word (command 1) names an output
// (row, col) and yields one pixel_out. Software programs src_width,
// src_height (0 acts as 1, above 256 as 256) and row_scale / col_scale as
// source over destination in unsigned Q9.16 at byte addresses 0, 4, 8, 12;
// write them only while the block is idle. A load uses the frame store port
// once, a compute uses it four times, once per neighbour read, since the
// store is a single-port memory; the front maps coordinates and runs ahead
// through a two-word queue. A compute result passes the read, product and
// accumulate registers into the output buffer, where two results may wait.
// The frame store has no reset and no clearing pass: read only pixels that
// were loaded.
`default_nettype none
module bilinear_image_resize (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic command,
    input  wire logic [bir_pkg::IDX_W-1:0] pos_row,
    input  wire logic [bir_pkg::IDX_W-1:0] pos_col,
    input  wire logic [bir_pkg::PIX_W-1:0] pixel_in,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [bir_pkg::PIX_W-1:0] pixel_out,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [bir_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bir_pkg::DATA_W-1:0] pwdata,
    output logic [bir_pkg::DATA_W-1:0] prdata,
    output logic      pready
);
    import bir_pkg::*;

    bir_cfg_t  cfg_reg;
    reg_idx_t  reg_idx;
    logic      cfg_wr;
    logic      job_valid;
    logic      job_ready;
    bir_job_t  job;
    logic      q_valid;
    logic      q_ready;
    bir_job_t  q_job;

    // Register file: written in the access phase, zero wait states.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= SIZE_W'(MAX_DIM);
            cfg_reg.src_height <= SIZE_W'(MAX_DIM);
            cfg_reg.row_scale  <= SCALE_W'(1) << FRAC_W;
            cfg_reg.col_scale  <= SCALE_W'(1) << FRAC_W;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[SIZE_W-1:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[SIZE_W-1:0];
                REG_ROW_SCALE:  cfg_reg.row_scale  <= pwdata[SCALE_W-1:0];
                REG_COL_SCALE:  cfg_reg.col_scale  <= pwdata[SCALE_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Read back, zero-extended.
    always_comb
    begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = DATA_W'(cfg_reg.src_width);
            REG_SRC_HEIGHT: prdata = DATA_W'(cfg_reg.src_height);
            REG_ROW_SCALE:  prdata = DATA_W'(cfg_reg.row_scale);
            REG_COL_SCALE:  prdata = DATA_W'(cfg_reg.col_scale);
            default:        prdata = '0;
        endcase
    end

    // Front: hold one word, map both axes, hand it on.
    bir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .pos_row   (pos_row),
        .pos_col   (pos_col),
        .pixel_in  (pixel_in),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Decouple front from the store sequencer.
    bir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_job   (job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    // Back: write loads, read four neighbours per compute, blend and round.
    bir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

endmodule
`default_nettype wire

// File: dv/tb_bilinear_image_resize.sv
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_image_resize: directed and random load and
// compute words, checked against a behavioral bilinear predictor kept in this file.
// Depends on bir_pkg and the bilinear_image_resize RTL.
module tb_bilinear_image_resize;
    import bir_pkg::*;

    // Scale registers carry 16 fraction bits, same as the blend weights.
    localparam int SCALE_FRAC = 16;
    // Margin after the last result so trailing loads finish inside the block.
    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;
    // Random phases with special treatment of the handshakes.
    localparam int PRESSURE_PHASE = 2;
    localparam int QUIET_SEND_PHASE = 4;
    localparam int QUIET_RECV_PHASE = 6;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PIX_W-1:0]  pix;
    } resize_word_t;

    // Two neighbour indices and the weight of the upper one on one axis.
    typedef struct packed {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [FRAC_W-1:0] frac;
    } axis_pick_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    wire               in_ready;
    logic              command = CMD_LOAD;
    logic [IDX_W-1:0]  pos_row = '0;
    logic [IDX_W-1:0]  pos_col = '0;
    logic [PIX_W-1:0]  pixel_in = '0;
    wire               out_valid;
    logic              out_ready = 1'b0;
    wire [PIX_W-1:0]   pixel_out;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    wire [DATA_W-1:0]  prdata;
    wire               pready;

    // Register copy, updated as each write lands; starts at the reset values.
    logic [SIZE_W-1:0]  cfg_width = SIZE_W'(MAX_DIM);
    logic [SIZE_W-1:0]  cfg_height = SIZE_W'(MAX_DIM);
    logic [SCALE_W-1:0] cfg_row_scale = SCALE_W'(1 << SCALE_FRAC);
    logic [SCALE_W-1:0] cfg_col_scale = SCALE_W'(1 << SCALE_FRAC);

    // Frame store copy, written as load words are accepted. The loaded flags are
    // set when a load is queued and keep every compute off never-written pixels.
    logic [PIX_W-1:0] frame_mirror [0:MAX_DIM*MAX_DIM-1];
    bit               pixel_loaded [0:MAX_DIM*MAX_DIM-1];

    resize_word_t     pending_words[$];
    logic [PIX_W-1:0] expected_pixels[$];

    int mismatches = 0;
    int words_accepted = 0;
    int loads_accepted = 0;
    int computes_accepted = 0;
    int results_seen = 0;
    int phase_no = -1;
    bit want_pressure = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;

    bilinear_image_resize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .pos_row   (pos_row),
        .pos_col   (pos_col),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // A size of zero acts as one, anything past the store acts as the store size.
    function automatic logic [63:0] eff_size(input logic [SIZE_W-1:0] size);
        if (size == 0)
            return 64'd1;
        if (size > MAX_DIM)
            return 64'(MAX_DIM);
        return 64'(size);
    endfunction

    // Map output index k to (k + 0.5) * scale - 0.5. The sum below is that
    // coordinate plus one, with one extra fraction bit, so it never goes
    // negative; its integer part is floor + 1. Clamping both neighbours to the
    // frame replicates the border on either side.
    function automatic axis_pick_t pick_axis(input logic [IDX_W-1:0] k,
                                             input logic [SCALE_W-1:0] scale,
                                             input logic [SIZE_W-1:0] size);
        logic [63:0] last;
        logic [63:0] coord;
        logic [63:0] ip;
        axis_pick_t  pick;
        last = eff_size(size) - 1;
        coord = (2 * 64'(k) + 1) * 64'(scale) + (64'd1 << SCALE_FRAC);
        coord = coord >> (SCALE_FRAC + 1 - FRAC_W);
        ip = coord >> FRAC_W;
        pick.frac = coord[FRAC_W-1:0];
        if (ip == 0)
            pick.lo = '0;
        else if (ip - 1 > last)
            pick.lo = IDX_W'(last);
        else
            pick.lo = IDX_W'(ip - 1);
        pick.hi = (ip > last) ? IDX_W'(last) : IDX_W'(ip);
        return pick;
    endfunction

    // Blend rows first, then columns, keeping every bit; the high and low
    // halves of the row blends are weighted apart so nothing overflows. One
    // round-half-up at the very end.
    function automatic logic [PIX_W-1:0] blend_pixel(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        axis_pick_t  rp;
        axis_pick_t  cp;
        logic [63:0] one;
        logic [63:0] fr;
        logic [63:0] fc;
        logic [63:0] left;
        logic [63:0] right;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [63:0] rounded;
        rp = pick_axis(row, cfg_row_scale, cfg_height);
        cp = pick_axis(col, cfg_col_scale, cfg_width);
        one = 64'd1 << FRAC_W;
        fr = 64'(rp.frac);
        fc = 64'(cp.frac);
        left = (one - fr) * 64'(frame_mirror[{rp.lo, cp.lo}])
             + fr * 64'(frame_mirror[{rp.hi, cp.lo}]);
        right = (one - fr) * 64'(frame_mirror[{rp.lo, cp.hi}])
              + fr * 64'(frame_mirror[{rp.hi, cp.hi}]);
        upper = (one - fc) * (left >> FRAC_W) + fc * (right >> FRAC_W);
        lower = (one - fc) * (left & (one - 1)) + fc * (right & (one - 1));
        rounded = lower + (64'd1 << (2 * FRAC_W - 1));
        return PIX_W'((upper + (rounded >> FRAC_W)) >> FRAC_W);
    endfunction

    // Apply one accepted word: loads update the store copy, computes queue a pixel.
    task automatic predict_word(input resize_word_t word);
        words_accepted++;
        if (word.cmd == CMD_LOAD) begin
            frame_mirror[{word.row, word.col}] = word.pix;
            loads_accepted++;
        end
        else begin
            expected_pixels.push_back(blend_pixel(word.row, word.col));
            computes_accepted++;
        end
    endtask

    task automatic queue_load(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                              input logic [PIX_W-1:0] pix);
        resize_word_t word;
        word.cmd = CMD_LOAD;
        word.row = row;
        word.col = col;
        word.pix = pix;
        pending_words.push_back(word);
        pixel_loaded[{row, col}] = 1'b1;
    endtask

    task automatic load_if_missing(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        if (!pixel_loaded[{row, col}])
            queue_load(row, col, PIX_W'($urandom));
    endtask

    // Queue a compute word, preceded by loads of any neighbour not yet written.
    task automatic queue_compute(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        axis_pick_t   rp;
        axis_pick_t   cp;
        resize_word_t word;
        rp = pick_axis(row, cfg_row_scale, cfg_height);
        cp = pick_axis(col, cfg_col_scale, cfg_width);
        load_if_missing(rp.lo, cp.lo);
        load_if_missing(rp.lo, cp.hi);
        load_if_missing(rp.hi, cp.lo);
        load_if_missing(rp.hi, cp.hi);
        word.cmd = CMD_COMPUTE;
        word.row = row;
        word.col = col;
        word.pix = PIX_W'($urandom);
        pending_words.push_back(word);
    endtask

    // Number of output indices that land inside the frame on one axis.
    function automatic int out_span(input logic [SIZE_W-1:0] size,
                                    input logic [SCALE_W-1:0] scale);
        logic [63:0] span;
        if (scale == 0)
            return MAX_DIM;
        span = (eff_size(size) << SCALE_FRAC) / 64'(scale) + 1;
        return (span > MAX_DIM) ? MAX_DIM : int'(span);
    endfunction

    // Mostly computes inside the mapped frame; the rest are refresh loads,
    // loads anywhere in the store and computes at any output index.
    task automatic queue_random_item();
        int sel;
        int rows;
        int cols;
        sel = $urandom_range(99);
        rows = int'(eff_size(cfg_height));
        cols = int'(eff_size(cfg_width));
        if (sel < 25)
            queue_load(IDX_W'($urandom_range(rows - 1)), IDX_W'($urandom_range(cols - 1)),
                       PIX_W'($urandom));
        else if (sel < 35)
            queue_load(IDX_W'($urandom), IDX_W'($urandom), PIX_W'($urandom));
        else if (sel < 45)
            queue_compute(IDX_W'($urandom), IDX_W'($urandom));
        else
            queue_compute(IDX_W'($urandom_range(out_span(cfg_height, cfg_row_scale) - 1)),
                          IDX_W'($urandom_range(out_span(cfg_width, cfg_col_scale) - 1)));
    endtask

    // Mostly small frames keep the number of fill loads low.
    function automatic int pick_size();
        return ($urandom_range(7) == 0) ? MAX_DIM : int'($urandom_range(1, 16));
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale(input int size);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return ($urandom_range(1) == 1) ? '1 : '0;
        if (sel == 1)
            return SCALE_W'($urandom_range(256, 16777216));
        return SCALE_W'((longint'(size) << SCALE_FRAC) / $urandom_range(1, MAX_DIM));
    endfunction

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge that closes the access cycle, since pready never drops.
    task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  cfg_width = value[SIZE_W-1:0];
            REG_SRC_HEIGHT: cfg_height = value[SIZE_W-1:0];
            REG_ROW_SCALE:  cfg_row_scale = value[SCALE_W-1:0];
            REG_COL_SCALE:  cfg_col_scale = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued word went in and every pixel came out, then let
    // trailing loads finish inside the block.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic setup_phase(input logic [DATA_W-1:0] width, input logic [DATA_W-1:0] height,
                               input logic [DATA_W-1:0] row_scale,
                               input logic [DATA_W-1:0] col_scale);
        drain();
        cfg_write(REG_SRC_WIDTH, width);
        cfg_write(REG_SRC_HEIGHT, height);
        cfg_write(REG_ROW_SCALE, row_scale);
        cfg_write(REG_COL_SCALE, col_scale);
    endtask

    // Input side: hold the word until accepted, then advance to the next
    // pending one, idling now and then except in the quiet sender phase.
    always @(posedge clk or negedge rst_n) begin : drive_words
        resize_word_t word;
        if (!rst_n) begin
            in_valid <= 1'b0;
            command <= CMD_LOAD;
            pos_row <= '0;
            pos_col <= '0;
            pixel_in <= '0;
        end
        else begin
            if (in_valid && in_ready) begin
                word.cmd = command;
                word.row = pos_row;
                word.col = pos_col;
                word.pix = pixel_in;
                predict_word(word);
            end
            if (!in_valid || in_ready) begin
                if (pending_words.size() != 0
                    && (phase_no == QUIET_SEND_PHASE || $urandom_range(99) >= 7)) begin
                    word = pending_words.pop_front();
                    command <= word.cmd;
                    pos_row <= word.row;
                    pos_col <= word.col;
                    pixel_in <= word.pix;
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted pixel against the oldest prediction.
    // Once, on request, drop ready for a long stretch so the block backs up
    // and stalls its input; otherwise idle now and then.
    always @(posedge clk or negedge rst_n) begin : check_pixels
        logic [PIX_W-1:0] want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t: pixel_out %h arrived with no compute word pending",
                             $time, pixel_out);
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want) begin
                        mismatches++;
                        $display("%0t: pixel_out mismatch: expected %h actual %h",
                                 $time, want, pixel_out);
                    end
                end
            end
            if (want_pressure && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= (phase_no == QUIET_RECV_PHASE) || ($urandom_range(99) >= 7);
            end
        end
    end

    // Watchdog: any handshake or register access counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without progress",
                     $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int width;
        int height;
        logic [SCALE_W-1:0] row_scale;
        logic [SCALE_W-1:0] col_scale;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, unit scale: pixel and index extremes at the corners;
        // each compute lands exactly on one source pixel.
        queue_load(IDX_W'(0), IDX_W'(0), 16'hFFFF);
        queue_load(IDX_W'(255), IDX_W'(255), 16'h0000);
        queue_load(IDX_W'(0), IDX_W'(255), 16'hA5A5);
        queue_load(IDX_W'(255), IDX_W'(0), 16'h5A5A);
        queue_compute(IDX_W'(0), IDX_W'(0));
        queue_compute(IDX_W'(255), IDX_W'(255));
        queue_compute(IDX_W'(0), IDX_W'(255));

        // Upscale of a tiny frame: the first output maps below zero, the last
        // far beyond the edge, the middle one blends four real neighbours.
        setup_phase(4, 3, 32768, 16384);
        queue_compute(IDX_W'(0), IDX_W'(0));
        queue_compute(IDX_W'(255), IDX_W'(255));
        queue_compute(IDX_W'(1), IDX_W'(2));

        // Zero sizes act as one, zero scales pin every output to index 0.
        setup_phase(0, 0, 0, 0);
        queue_compute(IDX_W'(7), IDX_W'(200));
        queue_compute(IDX_W'(255), IDX_W'(0));

        // Oversized frame registers, the largest scale and a scale of 1/256.
        setup_phase(511, 300, 32'h01FF_FFFF, 256);
        queue_compute(IDX_W'(0), IDX_W'(0));
        queue_compute(IDX_W'(255), IDX_W'(255));
        queue_compute(IDX_W'(128), IDX_W'(3));

        // Random phases; junk above the register widths must be dropped.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            width = pick_size();
            height = pick_size();
            row_scale = pick_scale(height);
            col_scale = pick_scale(width);
            setup_phase(DATA_W'(width) | ($urandom << SIZE_W),
                        DATA_W'(height) | ($urandom << SIZE_W),
                        DATA_W'(row_scale) | ($urandom << SCALE_W),
                        DATA_W'(col_scale) | ($urandom << SCALE_W));
            phase_no <= p;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                queue_random_item();
            if (p == PRESSURE_PHASE)
                want_pressure <= 1'b1;
        end

        drain();
        $display("Run covered %0d words (%0d loads, %0d computes), %0d pixels checked,",
                 words_accepted, loads_accepted, computes_accepted, results_seen);
        $display("across %0d register settings including size and scale extremes",
                 4 + RANDOM_PHASES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
